FILE: design/dq_pkg.sv
`default_nettype none

package dq_pkg;

  localparam int unsigned DqDepth = 1024;
  localparam int unsigned WordW = 32;
  localparam int unsigned OccW = 11;

  localparam logic [WordW-1:0] NoneWord = '1;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]              command;
    logic signed [WordW-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [WordW-1:0] popped_value;
    logic                    pop_ok;
    logic signed [WordW-1:0] front_value;
    logic signed [WordW-1:0] back_value;
    logic [OccW-1:0]         occupancy;
    logic                    is_empty;
    logic                    overflow;
  } rsp_t;

endpackage

`default_nettype wire

FILE: design/double_ended_queue_unit.sv
// channel   direction  handshake                payload
// in        request    in_valid_i / in_ready_o   in_req_i   (dq_pkg::req_t)
// out       result     out_valid_o / out_ready_i out_rsp_o  (dq_pkg::rsp_t)
//
// one request at a time: idle, execute, then for a pop that leaves words held a
// read state (one slot read from the ring memory to refresh the cached end),
// then the result state, and back to idle before the next request is taken
// the output register holds a result while the next request is taken and run
// rst_ni clears pointers, count and handshake state; ring contents stay unknown
`default_nettype none

module double_ended_queue_unit #(
  parameter int unsigned Depth = dq_pkg::DqDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire dq_pkg::req_t in_req_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output dq_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned WW = dq_pkg::WordW;
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  dq_pkg::state_e state_q, state_d;

  logic [2:0]    cmd_q, cmd_d;
  logic [WW-1:0] val_q, val_d;
  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic [WW-1:0] front_val_q, front_val_d;
  logic [WW-1:0] back_val_q, back_val_d;
  logic [WW-1:0] popped_q, popped_d;
  logic          pop_ok_q, pop_ok_d;
  logic          ovf_q, ovf_d;
  logic          rd_front_q, rd_front_d;
  logic          out_valid_q, out_valid_d;
  dq_pkg::rsp_t  out_rsp_q, out_rsp_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  logic          full;
  logic          empty;
  logic          is_pop;
  logic          out_free;
  logic [AW-1:0] front_next, front_prev, back_next, back_prev;

  assign full     = (count_q == FullCnt);
  assign empty    = (count_q == '0);
  assign is_pop   = (cmd_q == dq_pkg::CMD_POP_FRONT) || (cmd_q == dq_pkg::CMD_POP_BACK);
  assign out_free = !out_valid_q || out_ready_i;

  assign front_next = (front_q == LastIdx) ? '0 : front_q + AW'(1);
  assign front_prev = (front_q == '0) ? LastIdx : front_q - AW'(1);
  assign back_next  = (back_q == LastIdx) ? '0 : back_q + AW'(1);
  assign back_prev  = (back_q == '0) ? LastIdx : back_q - AW'(1);

  dq_ram #(
    .Width(WW),
    .Depth(Depth)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(val_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = dq_pkg::ST_EXEC;
        end
      end
      dq_pkg::ST_EXEC: begin
        if (is_pop && (count_q > CW'(1))) begin
          state_d = dq_pkg::ST_READ;
        end else begin
          state_d = dq_pkg::ST_RESP;
        end
      end
      dq_pkg::ST_READ: begin
        state_d = dq_pkg::ST_RESP;
      end
      dq_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = dq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = front_prev;
    ram_re      = 1'b0;
    ram_raddr   = front_next;
    cmd_d       = cmd_q;
    val_d       = val_q;
    front_d     = front_q;
    back_d      = back_q;
    count_d     = count_q;
    front_val_d = front_val_q;
    back_val_d  = back_val_q;
    popped_d    = popped_q;
    pop_ok_d    = pop_ok_q;
    ovf_d       = ovf_q;
    rd_front_d  = rd_front_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;

    case (state_q)
      dq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_d      = in_req_i.command;
        val_d      = in_req_i.push_value;
      end
      dq_pkg::ST_EXEC: begin
        popped_d = dq_pkg::NoneWord;
        pop_ok_d = 1'b0;
        ovf_d    = 1'b0;
        case (cmd_q)
          dq_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
              ovf_d = 1'b1;
            end else begin
              ram_we      = 1'b1;
              ram_waddr   = front_prev;
              front_d     = front_prev;
              count_d     = count_q + CW'(1);
              front_val_d = val_q;
              if (empty) begin
                back_val_d = val_q;
              end
            end
          end
          dq_pkg::CMD_PUSH_BACK: begin
            if (full) begin
              ovf_d = 1'b1;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = back_next;
              back_d     = back_next;
              count_d    = count_q + CW'(1);
              back_val_d = val_q;
              if (empty) begin
                front_val_d = val_q;
              end
            end
          end
          dq_pkg::CMD_POP_FRONT: begin
            if (!empty) begin
              popped_d   = front_val_q;
              pop_ok_d   = 1'b1;
              front_d    = front_next;
              count_d    = count_q - CW'(1);
              ram_re     = 1'b1;
              ram_raddr  = front_next;
              rd_front_d = 1'b1;
            end
          end
          dq_pkg::CMD_POP_BACK: begin
            if (!empty) begin
              popped_d   = back_val_q;
              pop_ok_d   = 1'b1;
              back_d     = back_prev;
              count_d    = count_q - CW'(1);
              ram_re     = 1'b1;
              ram_raddr  = back_prev;
              rd_front_d = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      dq_pkg::ST_READ: begin
        // refresh the cached end from the ring
        if (rd_front_q) begin
          front_val_d = ram_rdata;
        end else begin
          back_val_d = ram_rdata;
        end
      end
      dq_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_rsp_d.popped_value = popped_q;
          out_rsp_d.pop_ok       = pop_ok_q;
          out_rsp_d.front_value  = empty ? dq_pkg::NoneWord : front_val_q;
          out_rsp_d.back_value   = empty ? dq_pkg::NoneWord : back_val_q;
          out_rsp_d.occupancy    = dq_pkg::OccW'(count_q);
          out_rsp_d.is_empty     = empty;
          out_rsp_d.overflow     = ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::ST_IDLE;
      front_q     <= '0;
      back_q      <= LastIdx;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    val_q       <= val_d;
    front_val_q <= front_val_d;
    back_val_q  <= back_val_d;
    popped_q    <= popped_d;
    pop_ok_q    <= pop_ok_d;
    ovf_q       <= ovf_d;
    rd_front_q  <= rd_front_d;
    out_rsp_q   <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("count beyond ring depth");

  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == dq_pkg::ST_EXEC) && !full)
    else $error("ring write outside execute or when full");

  a_read_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dq_pkg::ST_READ) |-> $past(ram_re))
    else $error("read state without a ring read");

  a_pop_ovf_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_rsp_q.pop_ok && out_rsp_q.overflow))
    else $error("pop and overflow in one result");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rsp_q.is_empty) |->
      (out_rsp_q.front_value == dq_pkg::NoneWord) &&
      (out_rsp_q.back_value == dq_pkg::NoneWord))
    else $error("empty result with an end value");

endmodule

`default_nettype wire

FILE: design/dq_ram.sv
`default_nettype none

module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned HoldLen = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  dq_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  dq_pkg::rsp_t out_rsp_o;

  // shadow of the ring and its pointers
  logic [dq_pkg::WordW-1:0] ring_words [dq_pkg::DqDepth];
  int unsigned head_idx = 0;
  int unsigned fill = 0;

  dq_pkg::rsp_t due_results[$];
  int unsigned err_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  double_ended_queue_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic dq_pkg::rsp_t deque_apply(input logic [2:0] cmd,
                                               input logic [dq_pkg::WordW-1:0] val);
    dq_pkg::rsp_t r;
    r = '0;
    r.popped_value = dq_pkg::NoneWord;
    r.front_value = dq_pkg::NoneWord;
    r.back_value = dq_pkg::NoneWord;
    case (cmd)
      dq_pkg::CMD_PUSH_FRONT: begin
        if (fill == dq_pkg::DqDepth) begin
          r.overflow = 1'b1;
        end else begin
          head_idx = (head_idx == 0) ? dq_pkg::DqDepth - 1 : head_idx - 1;
          ring_words[head_idx] = val;
          fill++;
        end
      end
      dq_pkg::CMD_PUSH_BACK: begin
        if (fill == dq_pkg::DqDepth) begin
          r.overflow = 1'b1;
        end else begin
          ring_words[(head_idx + fill) % dq_pkg::DqDepth] = val;
          fill++;
        end
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (fill != 0) begin
          r.popped_value = ring_words[head_idx];
          r.pop_ok = 1'b1;
          head_idx = (head_idx + 1) % dq_pkg::DqDepth;
          fill--;
        end
      end
      dq_pkg::CMD_POP_BACK: begin
        if (fill != 0) begin
          r.popped_value = ring_words[(head_idx + fill - 1) % dq_pkg::DqDepth];
          r.pop_ok = 1'b1;
          fill--;
        end
      end
      default: ;
    endcase
    if (fill != 0) begin
      r.front_value = ring_words[head_idx];
      r.back_value = ring_words[(head_idx + fill - 1) % dq_pkg::DqDepth];
    end
    r.occupancy = fill[dq_pkg::OccW-1:0];
    r.is_empty = (fill == 0);
    return r;
  endfunction

  task automatic send(input logic [2:0] cmd, input logic [dq_pkg::WordW-1:0] val);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{command: cmd, push_value: val};
    do @(posedge clk_i); while (!in_ready_o);
    due_results.insert(due_results.size(), deque_apply(cmd, val));
  endtask

  task automatic check_field(input string name, input logic [dq_pkg::WordW-1:0] want,
                             input logic [dq_pkg::WordW-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    dq_pkg::rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result expected none actual %h", $time, out_rsp_o);
      end else begin
        want = due_results[0];
        due_results.delete(0);
        check_field("popped_value", want.popped_value, out_rsp_o.popped_value);
        check_field("pop_ok", 32'(want.pop_ok), 32'(out_rsp_o.pop_ok));
        check_field("front_value", want.front_value, out_rsp_o.front_value);
        check_field("back_value", want.back_value, out_rsp_o.back_value);
        check_field("occupancy", 32'(want.occupancy), 32'(out_rsp_o.occupancy));
        check_field("is_empty", 32'(want.is_empty), 32'(out_rsp_o.is_empty));
        check_field("overflow", 32'(want.overflow), 32'(out_rsp_o.overflow));
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldLen;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send(dq_pkg::CMD_QUERY, 32'h0);
    send(dq_pkg::CMD_POP_FRONT, 32'h1234_5678);
    send(dq_pkg::CMD_POP_BACK, 32'h0);
    send(3'd5, 32'hdead_beef);
    send(3'd6, 32'h0);
    send(3'd7, 32'hffff_ffff);
    send(dq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff);
    send(dq_pkg::CMD_PUSH_BACK, 32'h8000_0000);
    send(dq_pkg::CMD_PUSH_FRONT, 32'h0);
    send(dq_pkg::CMD_PUSH_BACK, 32'hffff_ffff);
    send(dq_pkg::CMD_QUERY, 32'h5555_5555);
    send(dq_pkg::CMD_POP_BACK, 32'h0);
    send(dq_pkg::CMD_POP_FRONT, 32'h0);
    send(dq_pkg::CMD_POP_FRONT, 32'h0);
    send(dq_pkg::CMD_POP_BACK, 32'h0);
    send(dq_pkg::CMD_POP_FRONT, 32'h0);
    send(dq_pkg::CMD_PUSH_BACK, 32'h1);
    send(dq_pkg::CMD_PUSH_BACK, 32'h2);
    send(dq_pkg::CMD_POP_BACK, 32'h0);
    send(dq_pkg::CMD_POP_BACK, 32'h0);
    send(dq_pkg::CMD_POP_BACK, 32'h0);
  endtask

  // both ends wrap across slot zero, then pops run the queue dry
  task automatic test_wrap_ends();
    idle_pct = 10;
    stall_pct = 10;
    repeat (6) send(dq_pkg::CMD_PUSH_FRONT, $urandom);
    repeat (6) send(dq_pkg::CMD_PUSH_BACK, $urandom);
    send(dq_pkg::CMD_QUERY, $urandom);
    repeat (4) send(dq_pkg::CMD_POP_BACK, $urandom);
    send(dq_pkg::CMD_PUSH_FRONT, $urandom);
    while (fill != 0) begin
      send($urandom_range(1) ? dq_pkg::CMD_POP_BACK : dq_pkg::CMD_POP_FRONT, $urandom);
    end
    send(dq_pkg::CMD_POP_FRONT, $urandom);
    send(dq_pkg::CMD_POP_BACK, $urandom);
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_reqs++;
    repeat (16) send(3'($urandom_range(3)), $urandom);
  endtask

  task automatic test_random(input int unsigned n, input int unsigned idle,
                             input int unsigned stall);
    int unsigned push_bias;
    int unsigned roll;
    logic [2:0] cmd;
    logic [dq_pkg::WordW-1:0] val;
    idle_pct = idle;
    stall_pct = stall;
    push_bias = 50;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 24 == 0) push_bias = $urandom_range(80, 20);
      roll = $urandom_range(99);
      if (roll < 6) cmd = dq_pkg::CMD_QUERY | 3'($urandom_range(3));
      else if (roll < 6 + push_bias * 94 / 100)
        cmd = $urandom_range(1) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT;
      else cmd = $urandom_range(1) ? dq_pkg::CMD_POP_BACK : dq_pkg::CMD_POP_FRONT;
      case ($urandom_range(7))
        0: val = 32'h7fff_ffff;
        1: val = 32'h8000_0000;
        2: val = 32'h0;
        default: val = $urandom;
      endcase
      send(cmd, val);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_wrap_ends();
    test_backpressure();
    test_random(120, 0, 0);
    test_random(120, 58, 0);
    test_random(120, 0, 58);
    test_random(120, 26, 26);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/dq_pkg.sv
design/dq_ram.sv
design/double_ended_queue_unit.sv
test/tb.sv
